FILE: rtl/mbrtu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants, CRC-16 helper and reply evaluation for the Modbus RTU read engine.
// No dependencies; every other file in rtl/ uses this package by scoped names.
package mbrtu_pkg;

    // Response capture limits
    localparam int RX_DEPTH      = 16;
    localparam int CNT_W         = $clog2(RX_DEPTH + 1);
    localparam int MAX_QUANTITY  = 2;
    localparam int MIN_FRAME_LEN = 5;    // slave, function, byte count / code, crc low, crc high
    localparam int KEEP_BYTES    = 7;    // header plus up to four data bytes
    localparam int DATA_BYTES    = 4;
    localparam int REQ_LEN       = 8;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [7:0]  EXC_FLAG = 8'h80;

    localparam logic [7:0] FC_READ_COILS    = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE = 8'd2;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_RX_BYTE = 2'd1,
        OP_TICK    = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TIMEOUT    = 3'd1,
        ST_EXCEPTION  = 3'd2,
        ST_BAD_HEADER = 3'd3,
        ST_BAD_CRC    = 3'd4,
        ST_BAD_LENGTH = 3'd5,
        ST_BUSY       = 3'd6
    } status_t;

    localparam logic KIND_REQ_BYTE = 1'b0;
    localparam logic KIND_RESULT   = 1'b1;

    typedef struct packed {
        status_t     status;
        logic [7:0]  exception_code;
        logic [31:0] data_word;
        logic [2:0]  data_len;
        logic [4:0]  received_len;
    } result_t;

    // Snapshot of the captured reply used to close a transaction
    typedef struct packed {
        logic [CNT_W-1:0]               cnt;
        logic [KEEP_BYTES-1:0][7:0]     bytes;
        logic [7:0]                     prev_byte;
        logic [7:0]                     last_byte;
        logic [7:0]                     slave;
        logic [7:0]                     func;
        logic [2:0]                     exp_bytes;
        logic [15:0]                    crc_hist2;
    } rx_view_t;

    // Work handed from the transaction core to the output stage
    typedef struct packed {
        logic        valid;
        logic        is_frame;
        logic [7:0]  slave;
        logic [7:0]  func;
        logic [15:0] addr;
        logic [7:0]  qty;
        result_t     res;
    } bundle_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic result_t finish_eval(input rx_view_t v);
        result_t         r;
        logic [CNT_W:0]  min_len;
        logic [15:0]     exc_crc;
        logic [15:0]     tail_crc;
        logic [2:0]      lim;
        r        = '0;
        min_len  = (CNT_W+1)'(MIN_FRAME_LEN) + (CNT_W+1)'(v.exp_bytes);
        exc_crc  = {v.bytes[4], v.bytes[3]};
        tail_crc = {v.last_byte, v.prev_byte};
        lim      = (v.exp_bytes < 3'(DATA_BYTES)) ? v.exp_bytes : 3'(DATA_BYTES);
        r.received_len = 5'(v.cnt);
        if (({1'b0, v.cnt} >= (CNT_W+1)'(MIN_FRAME_LEN)) && ((v.bytes[1] & EXC_FLAG) != 8'h00)
            && (v.bytes[0] == v.slave) && (v.bytes[1] == (v.func | EXC_FLAG))
            && (exc_crc == v.crc_hist2))
        begin
            r.status         = ST_EXCEPTION;
            r.exception_code = v.bytes[2];
        end
        else if ({1'b0, v.cnt} < min_len)
            r.status = ST_TIMEOUT;
        else if ((v.bytes[0] != v.slave) || (v.bytes[1] != v.func))
            r.status = ST_BAD_HEADER;
        else if (tail_crc != v.crc_hist2)
            r.status = ST_BAD_CRC;
        else if (v.bytes[2] != {5'b0, v.exp_bytes})
            r.status = ST_BAD_LENGTH;
        else
        begin
            r.status   = ST_OK;
            r.data_len = v.exp_bytes;
            for (int i = 0; i < DATA_BYTES; i++)
            begin
                if (3'(i) < lim)
                    r.data_word = {r.data_word[23:0], v.bytes[3+i]};
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/modbus_rtu_read_transaction.sv
`timescale 1ns / 1ps
// Modbus RTU master read engine, top level: timeout register, transaction
// core and output stage. Depends on mbrtu_pkg, mbrtu_core and mbrtu_out.
//
// Each input transfer is a start request, a received bus byte or a one
// millisecond tick. A start while idle produces eight request-byte transfers
// (slave, function, address high/low, quantity high/low, CRC low/high, the
// last one flagged by tx_last); a start while a reply is still pending gives
// a single busy result. Reply bytes are captured (up to 16, further bytes are
// dropped) and the transaction closes with one result transfer when the
// minimum normal length has arrived, when five bytes of an exception reply
// have arrived, or when the tick count reaches response_timeout. Bytes and
// ticks seen while idle produce nothing. Rate: one input transfer per cycle
// for bytes and ticks while out_stall is low; each passes the input register
// and then the output register. A start request occupies the output register
// for all eight request bytes, with the CRC folded in a byte at a time, so the
// input stalls until the last one is taken. Write response_timeout (reset 1000)
// only while the engine is idle; cfg_ready is always high.
module modbus_rtu_read_transaction (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  slave_id,
    input  logic [7:0]  function_code,
    input  logic [15:0] register_address,
    input  logic [1:0]  quantity,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        out_kind,
    output logic [7:0]  tx_byte,
    output logic        tx_last,
    output logic [2:0]  status,
    output logic [7:0]  exception_code,
    output logic [31:0] data_word,
    output logic [2:0]  data_len,
    output logic [4:0]  received_len
);

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    logic [15:0]        timeout_reg, timeout_next;
    logic               slot_free;
    mbrtu_pkg::bundle_t bundle;

    // Configuration write: take every transfer, hold otherwise
    assign cfg_ready    = 1'b1;
    assign timeout_next = (cfg_valid && cfg_ready) ? cfg_data : timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RESET;
        else
            timeout_reg <= timeout_next;
    end

    // Request latch, reply capture, tick count and status evaluation
    mbrtu_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .slave_id         (slave_id),
        .function_code    (function_code),
        .register_address (register_address),
        .quantity         (quantity),
        .rx_byte          (rx_byte),
        .timeout          (timeout_reg),
        .slot_free        (slot_free),
        .bundle           (bundle)
    );

    // Output register: serialize request frames, present results
    mbrtu_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .bundle         (bundle),
        .slot_free      (slot_free),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_kind       (out_kind),
        .tx_byte        (tx_byte),
        .tx_last        (tx_last),
        .status         (status),
        .exception_code (exception_code),
        .data_word      (data_word),
        .data_len       (data_len),
        .received_len   (received_len)
    );

endmodule

FILE: rtl/mbrtu_core.sv
`timescale 1ns / 1ps
// Input register and transaction state: latches requests, captures reply bytes,
// counts ticks and evaluates the closing status. Depends on mbrtu_pkg.
module mbrtu_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             opcode,
    input  logic [7:0]             slave_id,
    input  logic [7:0]             function_code,
    input  logic [15:0]            register_address,
    input  logic [1:0]             quantity,
    input  logic [7:0]             rx_byte,
    input  logic [15:0]            timeout,
    input  logic                   slot_free,
    output mbrtu_pkg::bundle_t     bundle
);

    logic                  in_vld_reg, in_vld_next;
    mbrtu_pkg::opcode_t    op_reg;
    logic [7:0]            slave_in_reg;
    logic [7:0]            func_in_reg;
    logic [15:0]           addr_in_reg;
    logic [1:0]            qty_in_reg;
    logic [7:0]            byte_in_reg;

    logic                  awaiting_reg, awaiting_next;
    logic [mbrtu_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]            slave_reg, slave_next;
    logic [7:0]            func_reg, func_next;
    logic [2:0]            exp_reg, exp_next;
    logic [15:0]           hist0_reg, hist0_next;
    logic [15:0]           hist1_reg, hist1_next;
    logic [15:0]           hist2_reg, hist2_next;
    logic [15:0]           ticks_reg, ticks_next;
    logic [mbrtu_pkg::KEEP_BYTES-1:0][7:0] bytes_reg, bytes_next;
    logic [7:0]            prev_reg, prev_next;
    logic [7:0]            last_reg, last_next;

    logic                  fire;
    logic                  do_finish;
    logic [1:0]            q_clamped;
    mbrtu_pkg::rx_view_t   view;

    assign fire        = in_vld_reg && slot_free;
    assign in_stall    = in_vld_reg && !slot_free;
    assign in_vld_next = in_stall ? 1'b1 : in_valid;

    always_comb
    begin
        if (qty_in_reg == 2'd0)
            q_clamped = 2'd1;
        else if ({30'b0, qty_in_reg} > mbrtu_pkg::MAX_QUANTITY)
            q_clamped = 2'(mbrtu_pkg::MAX_QUANTITY);
        else
            q_clamped = qty_in_reg;
    end

    always_comb
    begin
        awaiting_next = awaiting_reg;
        cnt_next      = cnt_reg;
        slave_next    = slave_reg;
        func_next     = func_reg;
        exp_next      = exp_reg;
        hist0_next    = hist0_reg;
        hist1_next    = hist1_reg;
        hist2_next    = hist2_reg;
        ticks_next    = ticks_reg;
        bytes_next    = bytes_reg;
        prev_next     = prev_reg;
        last_next     = last_reg;
        do_finish     = 1'b0;
        bundle        = '0;

        if (fire)
        begin
            case (op_reg)
                mbrtu_pkg::OP_START:
                begin
                    bundle.valid = 1'b1;
                    if (awaiting_reg)
                        bundle.res.status = mbrtu_pkg::ST_BUSY;
                    else
                    begin
                        bundle.is_frame = 1'b1;
                        bundle.slave    = slave_in_reg;
                        bundle.func     = func_in_reg;
                        bundle.addr     = addr_in_reg;
                        bundle.qty      = {6'b0, q_clamped};
                        slave_next      = slave_in_reg;
                        func_next       = func_in_reg;
                        if ((func_in_reg == mbrtu_pkg::FC_READ_COILS)
                            || (func_in_reg == mbrtu_pkg::FC_READ_DISCRETE))
                            exp_next = 3'd1;
                        else
                            exp_next = {q_clamped, 1'b0};
                        awaiting_next = 1'b1;
                        cnt_next      = '0;
                        ticks_next    = '0;
                        hist0_next    = mbrtu_pkg::CRC_INIT;
                        hist1_next    = mbrtu_pkg::CRC_INIT;
                        hist2_next    = mbrtu_pkg::CRC_INIT;
                    end
                end
                mbrtu_pkg::OP_RX_BYTE:
                begin
                    if (awaiting_reg)
                    begin
                        // Take bytes until the buffer is full, drop beyond it; only the first KEEP_BYTES are stored
                        if (cnt_reg < mbrtu_pkg::CNT_W'(mbrtu_pkg::RX_DEPTH))
                        begin
                            if (cnt_reg < mbrtu_pkg::CNT_W'(mbrtu_pkg::KEEP_BYTES))
                                bytes_next[cnt_reg[2:0]] = byte_in_reg;
                            prev_next  = last_reg;
                            last_next  = byte_in_reg;
                            cnt_next   = cnt_reg + mbrtu_pkg::CNT_W'(1);
                            hist2_next = hist1_reg;
                            hist1_next = hist0_reg;
                            hist0_next = mbrtu_pkg::crc_feed(hist0_reg, byte_in_reg);
                        end
                        if (({1'b0, cnt_next} >= ((mbrtu_pkg::CNT_W+1)'(mbrtu_pkg::MIN_FRAME_LEN)
                                                 + (mbrtu_pkg::CNT_W+1)'(exp_reg)))
                            || ((cnt_next >= mbrtu_pkg::CNT_W'(mbrtu_pkg::MIN_FRAME_LEN))
                                && ((bytes_next[1] & mbrtu_pkg::EXC_FLAG) != 8'h00)))
                            do_finish = 1'b1;
                    end
                end
                mbrtu_pkg::OP_TICK:
                begin
                    if (awaiting_reg)
                    begin
                        if (ticks_reg != 16'hFFFF)
                            ticks_next = ticks_reg + 16'd1;
                        if (ticks_next >= timeout)
                            do_finish = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        view.cnt       = cnt_next;
        view.bytes     = bytes_next;
        view.prev_byte = prev_next;
        view.last_byte = last_next;
        view.slave     = slave_reg;
        view.func      = func_reg;
        view.exp_bytes = exp_reg;
        view.crc_hist2 = hist2_next;

        if (do_finish)
        begin
            bundle.valid  = 1'b1;
            bundle.res    = mbrtu_pkg::finish_eval(view);
            awaiting_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            awaiting_reg <= 1'b0;
            cnt_reg      <= '0;
            slave_reg    <= '0;
            func_reg     <= '0;
            exp_reg      <= '0;
            hist0_reg    <= mbrtu_pkg::CRC_INIT;
            hist1_reg    <= mbrtu_pkg::CRC_INIT;
            hist2_reg    <= mbrtu_pkg::CRC_INIT;
            ticks_reg    <= '0;
        end
        else
        begin
            in_vld_reg   <= in_vld_next;
            awaiting_reg <= awaiting_next;
            cnt_reg      <= cnt_next;
            slave_reg    <= slave_next;
            func_reg     <= func_next;
            exp_reg      <= exp_next;
            hist0_reg    <= hist0_next;
            hist1_reg    <= hist1_next;
            hist2_reg    <= hist2_next;
            ticks_reg    <= ticks_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg       <= mbrtu_pkg::opcode_t'(opcode);
            slave_in_reg <= slave_id;
            func_in_reg  <= function_code;
            addr_in_reg  <= register_address;
            qty_in_reg   <= quantity;
            byte_in_reg  <= rx_byte;
        end
        bytes_reg <= bytes_next;
        prev_reg  <= prev_next;
        last_reg  <= last_next;
    end

endmodule

FILE: rtl/mbrtu_out.sv
`timescale 1ns / 1ps
// Output register: sends a request frame one byte per transfer with a running
// CRC-16, or a single transaction result. Depends on mbrtu_pkg.
module mbrtu_out (
    input  logic                clk,
    input  logic                rst_n,
    input  mbrtu_pkg::bundle_t  bundle,
    output logic                slot_free,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                out_kind,
    output logic [7:0]          tx_byte,
    output logic                tx_last,
    output logic [2:0]          status,
    output logic [7:0]          exception_code,
    output logic [31:0]         data_word,
    output logic [2:0]          data_len,
    output logic [4:0]          received_len
);

    localparam logic [2:0] LAST_IDX = 3'(mbrtu_pkg::REQ_LEN - 1);
    localparam logic [2:0] CRC_LO_IDX = 3'(mbrtu_pkg::REQ_LEN - 2);

    logic               vld_reg, vld_next;
    logic               frame_reg, frame_next;
    logic [2:0]         idx_reg, idx_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         slave_reg;
    logic [7:0]         func_reg;
    logic [15:0]        addr_reg;
    logic [7:0]         qty_reg;
    mbrtu_pkg::result_t res_reg;

    logic               xfer;
    logic               last_unit;
    logic [7:0]         cur_byte;

    assign xfer      = vld_reg && !out_stall;
    assign last_unit = !frame_reg || (idx_reg == LAST_IDX);
    assign slot_free = !vld_reg || (xfer && last_unit);

    always_comb
    begin
        case (idx_reg)
            3'd0:    cur_byte = slave_reg;
            3'd1:    cur_byte = func_reg;
            3'd2:    cur_byte = addr_reg[15:8];
            3'd3:    cur_byte = addr_reg[7:0];
            3'd4:    cur_byte = 8'h00;
            3'd5:    cur_byte = qty_reg;
            3'd6:    cur_byte = crc_reg[7:0];
            default: cur_byte = crc_reg[15:8];
        endcase
    end

    always_comb
    begin
        vld_next   = vld_reg;
        frame_next = frame_reg;
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        if (slot_free)
        begin
            vld_next   = bundle.valid;
            frame_next = bundle.is_frame;
            idx_next   = '0;
            crc_next   = mbrtu_pkg::CRC_INIT;
        end
        else if (xfer)
        begin
            // Advance through the frame; fold payload bytes into the CRC
            idx_next = idx_reg + 3'd1;
            if (idx_reg < CRC_LO_IDX)
                crc_next = mbrtu_pkg::crc_feed(crc_reg, cur_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= 1'b0;
            frame_reg <= 1'b0;
            idx_reg   <= '0;
            crc_reg   <= mbrtu_pkg::CRC_INIT;
        end
        else
        begin
            vld_reg   <= vld_next;
            frame_reg <= frame_next;
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && bundle.valid)
        begin
            slave_reg <= bundle.slave;
            func_reg  <= bundle.func;
            addr_reg  <= bundle.addr;
            qty_reg   <= bundle.qty;
            res_reg   <= bundle.res;
        end
    end

    assign out_valid      = vld_reg;
    assign out_kind       = frame_reg ? mbrtu_pkg::KIND_REQ_BYTE : mbrtu_pkg::KIND_RESULT;
    assign tx_byte        = frame_reg ? cur_byte : 8'h00;
    assign tx_last        = frame_reg && (idx_reg == LAST_IDX);
    assign status         = frame_reg ? 3'(mbrtu_pkg::ST_OK) : 3'(res_reg.status);
    assign exception_code = frame_reg ? 8'h00 : res_reg.exception_code;
    assign data_word      = frame_reg ? 32'h0 : res_reg.data_word;
    assign data_len       = frame_reg ? 3'd0 : res_reg.data_len;
    assign received_len   = frame_reg ? 5'd0 : res_reg.received_len;

endmodule
